// ===== src/der_pkg.sv =====
package der_pkg;

    // request codes
    localparam logic [2:0] REQ_OTHER     = 3'd0;
    localparam logic [2:0] REQ_UP        = 3'd1;
    localparam logic [2:0] REQ_DOWN      = 3'd2;
    localparam logic [2:0] REQ_COLLISION = 3'd3;
    localparam logic [2:0] REQ_READ      = 3'd4;

    // event codes
    localparam logic [3:0] EV_NONE      = 4'd0;
    localparam logic [3:0] EV_FIRST     = 4'd1;
    localparam logic [3:0] EV_TOP       = 4'd7;
    localparam logic [3:0] EV_COLLISION = 4'd8;

    localparam logic [4:0] LIMIT_RESET = 5'd10;

    // speed = floor(adc * 100 / 1033): reciprocal estimate, then one correction
    localparam logic [16:0] SPEED_SCALE = 17'd100;
    localparam logic [22:0] SPEED_RECIP = 23'd6344;
    localparam int          SPEED_SHIFT = 16;
    localparam logic [16:0] SPEED_DIV   = 17'd1033;

    typedef struct packed {
        logic [2:0]  req_type;
        logic [9:0]  adc_sample;
        logic [63:0] time_text;
        logic [3:0]  read_slot;
    } t_der_in;

    typedef struct packed {
        logic [3:0]  event_code;
        logic [6:0]  speed;
        logic        stored;
        logic [3:0]  stored_slot;
        logic [4:0]  record_count;
        logic        read_valid;
        logic [63:0] read_time;
        logic [3:0]  read_event;
        logic [6:0]  read_speed;
    } t_der_out;

    typedef struct packed {
        logic load;
        logic eval;
        logic fix;
    } t_der_cmd;

endpackage

// ===== src/der_ram.sv =====
module der_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                i_clk,
    input  logic                                i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                    i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                    o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== src/der_ctrl.sv =====
module der_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    output logic              o_busy,
    output logic              o_done,
    output der_pkg::t_der_cmd o_cmd
);
    import der_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EVAL,
        S_FIX
    } t_state;

    t_state r_state;
    logic   r_busy;
    logic   r_done;
    logic   r_eval;
    logic   r_fix;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_busy  <= 1'b0;
            r_done  <= 1'b0;
            r_eval  <= 1'b0;
            r_fix   <= 1'b0;
        end else begin
            r_done <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_state <= S_EVAL;
                        r_busy  <= 1'b1;
                        r_eval  <= 1'b1;
                    end
                end
                S_EVAL: begin
                    r_state <= S_FIX;
                    r_eval  <= 1'b0;
                    r_fix   <= 1'b1;
                end
                S_FIX: begin
                    r_state <= S_IDLE;
                    r_busy  <= 1'b0;
                    r_fix   <= 1'b0;
                    r_done  <= 1'b1;
                end
                default: begin
                    r_state <= S_IDLE;
                    r_busy  <= 1'b0;
                    r_eval  <= 1'b0;
                    r_fix   <= 1'b0;
                end
            endcase
        end
    end

    assign o_busy    = r_busy;
    assign o_done    = r_done;
    assign o_cmd.load = i_start & ~r_busy;
    assign o_cmd.eval = r_eval;
    assign o_cmd.fix  = r_fix;

`ifndef SYNTH
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !r_busy) |=> (r_busy && r_eval))
        else $error("accepted item did not start evaluation");

    a_done_after_fix: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_done) |-> ($past(r_fix) && !r_busy))
        else $error("result strobe without a fix cycle");
`endif

endmodule

// ===== src/der_dp.sv =====
module der_dp #(
    parameter int LOG_DEPTH = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  der_pkg::t_der_cmd i_cmd,
    input  der_pkg::t_der_in  i_item,
    input  logic              i_cfg_we,
    input  logic [4:0]        i_cfg_wdata,
    output der_pkg::t_der_out o_result
);
    import der_pkg::*;

    localparam int AW = (LOG_DEPTH > 1) ? $clog2(LOG_DEPTH) : 1;
    localparam int CW = $clog2(LOG_DEPTH + 1);
    localparam int LW = (CW > 5) ? CW : 5;
    localparam int SW = ((LW > AW) ? LW : AW) + 1;
    localparam int RW = 64 + 4 + 7;

    // item latch
    logic [2:0]  r_req;
    logic [9:0]  r_adc;
    logic [63:0] r_time;
    logic [3:0]  r_rslot;

    // state
    logic [4:0]    r_log_limit;
    logic [3:0]    r_event;
    logic [CW-1:0] r_count;
    logic [AW-1:0] r_base;
    logic [6:0]    r_last_speed;

    // between eval and fix
    logic [6:0]  r_q0;
    logic [16:0] r_x100;
    logic        r_stored;
    logic [3:0]  r_slot;
    logic        r_rvalid;

    t_der_out r_out;

    logic [3:0]    n_event;
    logic          n_store;
    logic [LW-1:0] lim;
    logic [LW-1:0] cnt_ext;
    logic [LW-1:0] n_slot;
    logic [LW-1:0] n_count;
    logic [AW-1:0] base_inc;
    logic [AW-1:0] n_base;
    logic [SW-1:0] wsum;
    logic [SW-1:0] rsum;
    logic [AW-1:0] waddr;
    logic [AW-1:0] raddr;
    logic          rvalid;
    logic          ram_we;
    logic [RW-1:0] ram_wdata;
    logic [RW-1:0] ram_rdata;
    logic [22:0]   est_prod;
    logic [16:0]   back_prod;
    logic [16:0]   rem;
    logic [6:0]    speed_fix;

    always_comb begin
        n_event = r_event;
        n_store = 1'b0;
        case (r_req)
            REQ_UP: begin
                n_store = 1'b1;
                if (r_event == EV_COLLISION) begin
                    n_event = EV_FIRST;
                end else if (r_event < EV_TOP) begin
                    n_event = r_event + 4'd1;
                end else begin
                    n_event = EV_TOP;
                end
            end
            REQ_DOWN: begin
                if (r_event == EV_COLLISION) begin
                    n_event = EV_FIRST;
                    n_store = 1'b1;
                end else if (r_event != EV_NONE) begin
                    if (r_event > EV_FIRST) begin
                        n_event = r_event - 4'd1;
                    end
                    n_store = 1'b1;
                end
            end
            REQ_COLLISION: begin
                if (r_event != EV_COLLISION) begin
                    n_event = EV_COLLISION;
                    n_store = 1'b1;
                end
            end
            default: begin
                n_event = r_event;
            end
        endcase

        // limit clamped to 1..LOG_DEPTH
        if (r_log_limit == 5'd0) begin
            lim = LW'(1);
        end else if (LW'(r_log_limit) > LW'(LOG_DEPTH)) begin
            lim = LW'(LOG_DEPTH);
        end else begin
            lim = LW'(r_log_limit);
        end

        cnt_ext  = LW'(r_count);
        base_inc = (r_base == AW'(LOG_DEPTH - 1)) ? '0 : r_base + AW'(1);

        // full log: drop the oldest by moving the base on
        if (cnt_ext >= lim) begin
            n_slot  = lim - LW'(1);
            n_count = lim;
            n_base  = base_inc;
        end else begin
            n_slot  = cnt_ext;
            n_count = cnt_ext + LW'(1);
            n_base  = r_base;
        end

        wsum = SW'(n_base) + SW'(n_slot);
        if (wsum >= SW'(LOG_DEPTH)) begin
            wsum = wsum - SW'(LOG_DEPTH);
        end
        waddr = wsum[AW-1:0];

        rsum = SW'(r_base) + SW'(r_rslot);
        if (rsum >= SW'(LOG_DEPTH)) begin
            rsum = rsum - SW'(LOG_DEPTH);
        end
        raddr = rsum[AW-1:0];

        rvalid    = (r_req == REQ_READ) && (LW'(r_rslot) < cnt_ext);
        ram_we    = i_cmd.eval & n_store;
        ram_wdata = {r_time, n_event, r_last_speed};
        est_prod  = 23'(r_adc) * SPEED_RECIP;

        back_prod = 17'(r_q0) * SPEED_DIV;
        rem       = r_x100 - back_prod;
        speed_fix = r_q0 + 7'(rem >= SPEED_DIV);
    end

    der_ram #(
        .WIDTH (RW),
        .DEPTH (LOG_DEPTH)
    ) u_log (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (waddr),
        .i_wdata (ram_wdata),
        .i_raddr (raddr),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_log_limit  <= LIMIT_RESET;
            r_event      <= EV_NONE;
            r_count      <= '0;
            r_base       <= '0;
            r_last_speed <= '0;
        end else begin
            if (i_cfg_we) begin
                r_log_limit <= i_cfg_wdata;
            end
            if (i_cmd.eval) begin
                r_event <= n_event;
                if (n_store) begin
                    r_count <= n_count[CW-1:0];
                    r_base  <= n_base;
                end
            end
            if (i_cmd.fix) begin
                r_last_speed <= speed_fix;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_req   <= i_item.req_type;
            r_adc   <= i_item.adc_sample;
            r_time  <= i_item.time_text;
            r_rslot <= i_item.read_slot;
        end
        if (i_cmd.eval) begin
            r_q0     <= est_prod[SPEED_SHIFT +: 7];
            r_x100   <= 17'(r_adc) * SPEED_SCALE;
            r_stored <= n_store;
            r_slot   <= n_store ? n_slot[3:0] : 4'd0;
            r_rvalid <= rvalid;
        end
        if (i_cmd.fix) begin
            r_out.event_code   <= r_event;
            r_out.speed        <= speed_fix;
            r_out.stored       <= r_stored;
            r_out.stored_slot  <= r_slot;
            r_out.record_count <= 5'(r_count);
            r_out.read_valid   <= r_rvalid;
            r_out.read_time    <= r_rvalid ? ram_rdata[RW-1 -: 64] : 64'd0;
            r_out.read_event   <= r_rvalid ? ram_rdata[10:7] : 4'd0;
            r_out.read_speed   <= r_rvalid ? ram_rdata[6:0] : 7'd0;
        end
    end

    assign o_result = r_out;

`ifndef SYNTH
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count <= CW'(LOG_DEPTH)) && (r_base <= AW'(LOG_DEPTH - 1)))
        else $error("log count or base out of range");

    a_fix_follows_eval: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.eval |=> (i_cmd.fix && !i_cmd.eval))
        else $error("fix cycle missing after evaluation");
`endif

endmodule

// ===== src/drive_event_recorder.sv =====
// Drive event recorder: event code keeper with a circular record log.
// o_done is a registered strobe raised after the accept, evaluate/log access and speed fix steps.
// A new item is accepted only once busy drops after the last item's speed fix step.
// Log access is one RAM port per item; the speed takes a reciprocal step then a fix step.
// Reset (synchronous, active low) clears code, count and limit to 10; log RAM is not cleared.
// The receiver cannot stall: o_done is high for one cycle per result; o_result holds until the next.
module drive_event_recorder #(
    parameter int LOG_DEPTH = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  der_pkg::t_der_in  i_item,
    input  logic              i_cfg_we,
    input  logic [4:0]        i_cfg_wdata,
    output logic              o_done,
    output der_pkg::t_der_out o_result
);
    import der_pkg::*;

    t_der_cmd cmd;

    // controller: sequences load, evaluate and fix, one item at a time
    der_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .o_busy  (busy),
        .o_done  (o_done),
        .o_cmd   (cmd)
    );

    // datapath: event rules, log pointers, log RAM and speed scaling
    der_dp #(
        .LOG_DEPTH (LOG_DEPTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_item      (i_item),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .o_result    (o_result)
    );

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 1ps

module tb;
    import der_pkg::*;

    localparam int LOG_DEPTH      = 16;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int PHASE_ITEMS    = 190;
    localparam int PHASES         = 10;

    // request codes the block treats as a plain tick
    localparam logic [2:0] REQ_SPARE_A = 3'd5;
    localparam logic [2:0] REQ_SPARE_B = 3'd6;
    localparam logic [2:0] REQ_SPARE_C = 3'd7;

    logic     i_clk       = 1'b0;
    logic     i_rst_n     = 1'b0;
    logic     start       = 1'b0;
    logic     busy;
    t_der_in  i_item      = '0;
    logic     i_cfg_we    = 1'b0;
    logic [4:0] i_cfg_wdata = '0;
    logic     o_done;
    t_der_out o_result;

    drive_event_recorder #(
        .LOG_DEPTH(LOG_DEPTH)
    ) uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_item      (i_item),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .o_done      (o_done),
        .o_result    (o_result)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Recorder mirror: event code, record count, previous speed and the
    // shifting log, plus the limit register as last written.
    // ------------------------------------------------------------------
    logic [4:0]  limit_reg;
    logic [3:0]  ev_now;
    logic [4:0]  rec_count;
    logic [6:0]  prev_speed;
    logic [63:0] log_time  [LOG_DEPTH];
    logic [3:0]  log_event [LOG_DEPTH];
    logic [6:0]  log_speed [LOG_DEPTH];

    t_der_out due_results[$];   // results owed by the block, oldest first
    int       mismatches = 0;
    int       idle_cycles = 0;

    // Apply one accepted item to the mirror and work out its result.
    task automatic advance_recorder(input t_der_in it, output t_der_out res);
        int         lim;
        int         slot;
        bit         keep;
        logic [6:0] spd;
        lim  = limit_reg;
        if (lim < 1) lim = 1;
        if (lim > LOG_DEPTH) lim = LOG_DEPTH;
        spd  = 7'((int'(it.adc_sample) * 100) / 1033);
        keep = 1'b0;
        slot = 0;
        res  = '0;

        case (it.req_type)
            REQ_UP: begin
                if (ev_now == EV_COLLISION) ev_now = EV_FIRST;
                else if (ev_now < EV_TOP) ev_now = ev_now + 4'd1;
                keep = 1'b1;
            end
            REQ_DOWN: begin
                if (ev_now == EV_COLLISION) begin
                    ev_now = EV_FIRST;
                    keep   = 1'b1;
                end else if (ev_now != EV_NONE) begin
                    if (ev_now > EV_FIRST) ev_now = ev_now - 4'd1;
                    keep = 1'b1;
                end
            end
            REQ_COLLISION: begin
                if (ev_now != EV_COLLISION) begin
                    ev_now = EV_COLLISION;
                    keep   = 1'b1;
                end
            end
            default: ;
        endcase

        if (keep) begin
            // full log (or a limit lowered under the count): drop the oldest
            if (rec_count >= lim) begin
                rec_count = 5'(lim);
                for (int i = 1; i < lim; i++) begin
                    log_time[i-1]  = log_time[i];
                    log_event[i-1] = log_event[i];
                    log_speed[i-1] = log_speed[i];
                end
                slot = lim - 1;
            end else begin
                slot      = rec_count;
                rec_count = rec_count + 5'd1;
            end
            log_time[slot]  = it.time_text;
            log_event[slot] = ev_now;
            log_speed[slot] = prev_speed;   // speed of the item before this one
        end
        prev_speed = spd;

        res.event_code   = ev_now;
        res.speed        = spd;
        res.stored       = keep;
        res.stored_slot  = 4'(slot);
        res.record_count = rec_count;
        if (it.req_type == REQ_READ && it.read_slot < rec_count) begin
            res.read_valid = 1'b1;
            res.read_time  = log_time[it.read_slot];
            res.read_event = log_event[it.read_slot];
            res.read_speed = log_speed[it.read_slot];
        end
    endtask

    // ------------------------------------------------------------------
    // Result checking. The receiver cannot stall, so every strobe is taken.
    // ------------------------------------------------------------------
    task automatic check_field(input string what, input logic [63:0] want,
                               input logic [63:0] got);
        if (want !== got) begin
            mismatches++;
            $display("%0t: %s expected %0h got %0h", $time, what, want, got);
        end
    endtask

    always @(posedge i_clk) begin
        t_der_out want;
        if (i_rst_n && o_done) begin
            if (due_results.size() == 0) begin
                mismatches++;
                $display("%0t: unexpected result, expected none got %0h",
                         $time, o_result);
            end else begin
                want = due_results.pop_front();
                check_field("event_code",   want.event_code,   o_result.event_code);
                check_field("speed",        want.speed,        o_result.speed);
                check_field("stored",       want.stored,       o_result.stored);
                check_field("stored_slot",  want.stored_slot,  o_result.stored_slot);
                check_field("record_count", want.record_count, o_result.record_count);
                check_field("read_valid",   want.read_valid,   o_result.read_valid);
                check_field("read_time",    want.read_time,    o_result.read_time);
                check_field("read_event",   want.read_event,   o_result.read_event);
                check_field("read_speed",   want.read_speed,   o_result.read_speed);
            end
        end
    end

    // Watchdog: too long without an item accepted or a result seen.
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_done) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("tb NOT OK");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Driving. start is only lowered for a gap or a drain, so back-to-back
    // items keep it high with a single assignment per edge.
    // ------------------------------------------------------------------
    task automatic send_item(input t_der_in it, input int gap, input bit typed,
                             input t_der_out want);
        t_der_out pred;
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_item <= it;
        start  <= 1'b1;
        do @(posedge i_clk); while (busy);
        advance_recorder(it, pred);
        // directed rows with a hand-written answer are held to that answer
        due_results.push_back(typed ? want : pred);
    endtask

    // Hold off the sender until every owed result is in.
    task automatic drain_results();
        start <= 1'b0;
        do @(posedge i_clk); while (due_results.size() != 0);
    endtask

    // Limit changes only with the block idle: owed results are drained first.
    task automatic write_limit(input logic [4:0] v);
        drain_results();
        repeat (4) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        limit_reg   = v;
    endtask

    // ------------------------------------------------------------------
    // Directed table
    // ------------------------------------------------------------------
    typedef struct {
        t_der_in  stim;
        bit       typed;
        t_der_out want;
    } t_row;

    t_row rows[$];

    task automatic add_row(input logic [2:0] rq, input logic [9:0] adc,
                           input logic [63:0] tt, input logic [3:0] rs,
                           input bit typed, input t_der_out want);
        t_row r;
        r.stim.req_type   = rq;
        r.stim.adc_sample = adc;
        r.stim.time_text  = tt;
        r.stim.read_slot  = rs;
        r.typed           = typed;
        r.want            = want;
        rows.push_back(r);
    endtask

    function automatic t_der_in random_item();
        t_der_in it;
        int      pick;
        pick = $urandom_range(0, 99);
        // mostly key traffic and reads; a little tick and spare-code noise
        if (pick < 8)       it.req_type = REQ_OTHER;
        else if (pick < 28) it.req_type = REQ_UP;
        else if (pick < 50) it.req_type = REQ_DOWN;
        else if (pick < 60) it.req_type = REQ_COLLISION;
        else if (pick < 90) it.req_type = REQ_READ;
        else                it.req_type = 3'($urandom_range(REQ_SPARE_A, REQ_SPARE_C));
        it.adc_sample = 10'($urandom_range(0, 1023));
        it.time_text  = {$urandom, $urandom};
        // half the reads aim inside the log, the rest anywhere
        if ($urandom_range(0, 1) == 0 || rec_count == 0)
            it.read_slot = 4'($urandom_range(0, 15));
        else
            it.read_slot = 4'($urandom_range(0, rec_count - 1));
        return it;
    endfunction

    logic [4:0] phase_limits [PHASES] = '{5'd16, 5'd3, 5'd0, 5'd31, 5'd1,
                                          5'd12, 5'd2, 5'd10, 5'd5, 5'd7};

    initial begin
        t_der_out none_out;
        t_der_in  it;
        none_out = '0;

        // mirror matches the block after reset
        limit_reg  = LIMIT_RESET;
        ev_now     = EV_NONE;
        rec_count  = '0;
        prev_speed = '0;

        // fresh block: empty read, down at code 0 (no record), top speed
        add_row(REQ_READ,      10'd0,    64'd0,       4'd0,  1'b1,
                t_der_out'({EV_NONE, 7'd0, 1'b0, 4'd0, 5'd0, 1'b0, 64'd0, 4'd0, 7'd0}));
        add_row(REQ_DOWN,      10'd1023, '1,          4'd15, 1'b1,
                t_der_out'({EV_NONE, 7'd99, 1'b0, 4'd0, 5'd0, 1'b0, 64'd0, 4'd0, 7'd0}));
        add_row(REQ_OTHER,     10'd1022, "00:00:01",  4'd0,  1'b0, none_out);
        // climb from 1 to the top code of 7
        add_row(REQ_UP,        10'd517,  "08:15:42",  4'd0,  1'b0, none_out);
        add_row(REQ_UP,        10'd341,  "08:15:43",  4'd1,  1'b0, none_out);
        add_row(REQ_UP,        10'd682,  "08:15:44",  4'd2,  1'b0, none_out);
        add_row(REQ_UP,        10'd512,  "08:15:45",  4'd4,  1'b0, none_out);
        add_row(REQ_UP,        10'd1,    "08:15:46",  4'd8,  1'b0, none_out);
        add_row(REQ_UP,        10'd1023, "08:15:47",  4'd0,  1'b0, none_out);
        add_row(REQ_UP,        10'd1022, "08:15:48",  4'd0,  1'b0, none_out);
        add_row(REQ_DOWN,      10'd200,  "08:16:00",  4'd0,  1'b0, none_out);
        // collision, repeated collision does nothing, up from collision
        add_row(REQ_COLLISION, 10'd0,    "08:16:05",  4'd0,  1'b0, none_out);
        add_row(REQ_COLLISION, 10'd999,  "08:16:06",  4'd0,  1'b0, none_out);
        add_row(REQ_UP,        10'd10,   "08:16:07",  4'd0,  1'b0, none_out);
        // eleventh record overflows the reset limit of ten
        add_row(REQ_COLLISION, 10'd103,  "08:16:08",  4'd0,  1'b0, none_out);
        add_row(REQ_DOWN,      10'd104,  "08:16:09",  4'd0,  1'b0, none_out);
        add_row(REQ_DOWN,      10'd105,  "08:16:10",  4'd0,  1'b0, none_out);
        // spare request codes behave as ticks
        add_row(REQ_SPARE_A,   10'd700,  "08:16:11",  4'd3,  1'b0, none_out);
        add_row(REQ_SPARE_B,   10'd800,  "08:16:12",  4'd5,  1'b0, none_out);
        add_row(REQ_SPARE_C,   10'd900,  "08:16:13",  4'd7,  1'b0, none_out);
        // reads: oldest, newest, one past the count, far beyond
        add_row(REQ_READ,      10'd300,  "08:16:14",  4'd0,  1'b0, none_out);
        add_row(REQ_READ,      10'd400,  "08:16:15",  4'd9,  1'b0, none_out);
        add_row(REQ_READ,      10'd0,    "08:16:16",  4'd10, 1'b1,
                t_der_out'({EV_FIRST, 7'd0, 1'b0, 4'd0, 5'd10, 1'b0, 64'd0, 4'd0, 7'd0}));
        add_row(REQ_READ,      10'd1023, "08:16:17",  4'd15, 1'b0, none_out);

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (rows[k])
            send_item(rows[k].stim, $urandom_range(0, 9), rows[k].typed, rows[k].want);

        // Random phases, each under its own limit. Every third phase runs
        // without gaps so the block is hit back to back.
        for (int p = 0; p < PHASES; p++) begin
            write_limit(phase_limits[p]);
            // reads first: a lowered limit still shows the old count here
            repeat (2) begin
                it           = random_item();
                it.req_type  = REQ_READ;
                it.read_slot = 4'($urandom_range(0, 15));
                send_item(it, $urandom_range(0, 9), 1'b0, none_out);
            end
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if ($urandom_range(0, 59) == 0)
                    drain_results();
                send_item(random_item(), (p % 3 == 1) ? 0 : $urandom_range(0, 9),
                          1'b0, none_out);
            end
        end

        drain_results();
        repeat (8) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("tb OK");
        end else begin
            $display("tb NOT OK");
        end
        $finish;
    end

endmodule
